// ===== src/kmpp_pkg.sv =====
// shared types and constants for the k-means++ seeding core
package kmpp_pkg;
  localparam int MAX_POINTS   = 64;
  localparam int MAX_CLUSTERS = 8;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_LOAD   = 2'd1;
  localparam logic [1:0] FUNC_SEED   = 2'd2;
  localparam logic [1:0] FUNC_ASSIGN = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_NO_PTS   = 3'd2;
  localparam logic [2:0] ST_ALL_DONE = 3'd3;
  localparam logic [2:0] ST_NO_CENT  = 3'd4;
  localparam logic [2:0] ST_BAD_IDX  = 3'd5;

  typedef logic signed [15:0] coord_t;
  typedef logic [32:0] dist_t;
endpackage

// ===== src/kmpp_dist.sv =====
// registered squared distance unit shared by all passes
module kmpp_dist
  import kmpp_pkg::*;
(
  input  logic   clk,
  input  coord_t ax,
  input  coord_t ay,
  input  coord_t bx,
  input  coord_t by,
  output dist_t  sqd
);
  logic signed [16:0] dx_r, dy_r;
  logic [33:0] sx_r, sy_r;

  always_ff @(posedge clk) begin
    dx_r <= 17'(ax) - 17'(bx);
    dy_r <= 17'(ay) - 17'(by);
    sx_r <= 34'(dx_r * dx_r);
    sy_r <= 34'(dy_r * dy_r);
  end

  assign sqd = 33'(sx_r + sy_r);
endmodule

// ===== src/kmeans_plus_plus_seeding_core.sv =====
// top level of the k-means++ seeding core
// Points are loaded one per transaction into a store of MAX_POINTS entries,
// then seed steps pick centroids by k-means++ and assign queries return the
// nearest centroid of a stored point. A seed step after the first runs the
// one shared squared distance unit over every point and every chosen
// centroid, then scans prefix sums, reading and then comparing each point in
// turn; the first step computes rand mod count by restoring subtraction.
// The block takes no new input while a transaction is in progress; the
// result waits in an output register.
module kmeans_plus_plus_seeding_core
  import kmpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_cluster_count,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  coord_t      in_x_coord,
  input  coord_t      in_y_coord,
  input  logic [15:0] in_rand_value,
  input  logic [5:0]  in_point_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [2:0]  out_centroid_number,
  output logic [5:0]  out_chosen_index,
  output coord_t      out_centroid_x,
  output coord_t      out_centroid_y,
  output logic [2:0]  out_group,
  output dist_t       out_min_distance
);
  localparam int PW = $clog2(MAX_POINTS);
  localparam int CW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int SW = 33 + PW;

  localparam logic [3:0] S_IDLE = 4'd0, S_MOD = 4'd1, S_DRD = 4'd2,
    S_DWAIT = 4'd3, S_DACC = 4'd4, S_SCAN_RD = 4'd5, S_SCAN = 4'd6,
    S_PICK_RD = 4'd7, S_PICK = 4'd8, S_OUT = 4'd9, S_ARD = 4'd10;

  logic [3:0] state_r;
  logic [3:0] ccount_r;
  logic [PW:0] pcount_r;
  logic [CW:0] chosen_r;
  logic [15:0] rand_r;
  logic [1:0]  func_r;
  logic [5:0]  pidx_r;

  coord_t px_mem [MAX_POINTS];
  coord_t py_mem [MAX_POINTS];
  dist_t  d_mem  [MAX_POINTS];
  coord_t cx_mem [MAX_CLUSTERS];
  coord_t cy_mem [MAX_CLUSTERS];

  logic [PW-1:0] pi_r;
  logic [CW:0]   ci_r;
  logic [2:0]    pipe_r;
  logic [CW-1:0] pipe_c [3];
  coord_t        px_r, py_r, cxr_r, cyr_r;
  dist_t         sqd, best_r;
  logic [CW-1:0] bestc_r;
  logic          bestv_r;
  logic [SW-1:0] sum_r, pre_r;
  logic [SW+15:0] target_r;
  dist_t         drd_r;
  logic [16:0]   rem_r;
  logic [4:0]    bit_r;
  logic [PW-1:0] pick_r;

  logic [CW:0] limit;
  always_comb begin
    if (ccount_r == 4'd0) limit = (CW+1)'(1);
    else if (32'(ccount_r) > MAX_CLUSTERS) limit = (CW+1)'(MAX_CLUSTERS);
    else limit = (CW+1)'(ccount_r);
  end

  kmpp_dist u_dist (.clk(clk), .ax(px_r), .ay(py_r), .bx(cxr_r), .by(cyr_r),
    .sqd(sqd));

  assign in_stall = (state_r != S_IDLE) || out_valid;
  wire acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) ccount_r <= 4'd2;
    else if (cfg_we) ccount_r <= cfg_cluster_count;
  end

  always_ff @(posedge clk) begin
    px_r  <= px_mem[pi_r];
    py_r  <= py_mem[pi_r];
    cxr_r <= cx_mem[ci_r[CW-1:0]];
    cyr_r <= cy_mem[ci_r[CW-1:0]];
    drd_r <= d_mem[pi_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; pcount_r <= '0; chosen_r <= '0; out_valid <= 1'b0;
      pipe_r <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      pipe_r <= {pipe_r[1:0], state_r == S_DRD};
      case (state_r)
        S_IDLE: if (acc) begin
          func_r <= in_func; rand_r <= in_rand_value; pidx_r <= in_point_index;
          out_status <= ST_OK; out_centroid_number <= '0; out_chosen_index <= '0;
          out_centroid_x <= '0; out_centroid_y <= '0; out_group <= '0;
          out_min_distance <= '0;
          case (in_func)
            FUNC_CLEAR: begin
              pcount_r <= '0; chosen_r <= '0; out_valid <= 1'b1;
            end
            FUNC_LOAD: begin
              if (32'(pcount_r) >= MAX_POINTS) out_status <= ST_FULL;
              else begin
                px_mem[pcount_r[PW-1:0]] <= in_x_coord;
                py_mem[pcount_r[PW-1:0]] <= in_y_coord;
                pcount_r <= pcount_r + 1'b1;
              end
              out_valid <= 1'b1;
            end
            FUNC_SEED: begin
              if (pcount_r == '0) begin
                out_status <= ST_NO_PTS; out_valid <= 1'b1;
              end else if (chosen_r >= limit) begin
                out_status <= ST_ALL_DONE; out_valid <= 1'b1;
              end else if (chosen_r == '0) begin
                rem_r <= '0; bit_r <= 5'd16; state_r <= S_MOD;
              end else begin
                pi_r <= '0; ci_r <= '0; sum_r <= '0; bestv_r <= 1'b0;
                state_r <= S_DRD;
              end
            end
            default: begin
              if (7'(in_point_index) >= 7'(pcount_r)) begin
                out_status <= ST_BAD_IDX; out_valid <= 1'b1;
              end else if (chosen_r == '0) begin
                out_status <= ST_NO_CENT; out_valid <= 1'b1;
              end else begin
                pi_r <= in_point_index[PW-1:0]; ci_r <= '0; bestv_r <= 1'b0;
                state_r <= S_DRD;
              end
            end
          endcase
        end
        S_MOD: begin
          if (bit_r == 5'd0) begin
            pick_r <= rem_r[PW-1:0]; pi_r <= rem_r[PW-1:0]; state_r <= S_PICK_RD;
          end else begin
            if ({rem_r[15:0], rand_r[15]} >= 17'(pcount_r))
              rem_r <= {rem_r[15:0], rand_r[15]} - 17'(pcount_r);
            else rem_r <= {rem_r[15:0], rand_r[15]};
            rand_r <= {rand_r[14:0], 1'b0};
            bit_r <= bit_r - 1'b1;
          end
        end
        S_DRD: begin
          pipe_c[0] <= ci_r[CW-1:0];
          if (ci_r + 1'b1 >= chosen_r) state_r <= S_DWAIT;
          else ci_r <= ci_r + 1'b1;
        end
        S_DWAIT: if (pipe_r == 3'b000) state_r <= S_DACC;
        S_DACC: begin
          if (func_r == FUNC_ASSIGN) begin
            out_group <= 3'(bestc_r); out_centroid_number <= 3'(bestc_r);
            out_chosen_index <= pidx_r; out_min_distance <= best_r;
            ci_r <= (CW+1)'(bestc_r); state_r <= S_ARD;
          end else begin
            d_mem[pi_r] <= best_r;
            sum_r <= sum_r + SW'(best_r);
            bestv_r <= 1'b0; ci_r <= '0;
            if (32'(pi_r) + 1 >= 32'(pcount_r)) begin
              pi_r <= '0; pre_r <= '0;
              pick_r <= PW'(pcount_r - 1'b1);
              state_r <= S_SCAN_RD;
            end else begin
              pi_r <= pi_r + 1'b1; state_r <= S_DRD;
            end
          end
        end
        S_SCAN_RD: begin
          target_r <= (SW+16)'(sum_r) * (SW+16)'(rand_r);
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if ({pre_r + SW'(drd_r), 16'd0} >= target_r) begin
            pick_r <= pi_r; state_r <= S_PICK_RD;
          end else if (32'(pi_r) + 1 >= 32'(pcount_r)) begin
            pi_r <= pick_r; state_r <= S_PICK_RD;
          end else begin
            pre_r <= pre_r + SW'(drd_r); pi_r <= pi_r + 1'b1; state_r <= S_SCAN_RD;
          end
        end
        S_PICK_RD: state_r <= S_PICK;
        S_PICK: begin
          cx_mem[chosen_r[CW-1:0]] <= px_r; cy_mem[chosen_r[CW-1:0]] <= py_r;
          out_centroid_number <= 3'(chosen_r); out_chosen_index <= 6'(pi_r);
          out_centroid_x <= px_r; out_centroid_y <= py_r;
          chosen_r <= chosen_r + 1'b1; out_valid <= 1'b1; state_r <= S_IDLE;
        end
        S_ARD: state_r <= S_OUT;
        S_OUT: begin
          out_centroid_x <= cxr_r; out_centroid_y <= cyr_r;
          out_valid <= 1'b1; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (pipe_r[2]) begin
        if (!bestv_r || sqd < best_r) begin
          best_r <= sqd; bestc_r <= pipe_c[2];
        end
        bestv_r <= 1'b1;
      end
    end
    pipe_c[1] <= pipe_c[0];
    pipe_c[2] <= pipe_c[1];
  end
endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the k-means++ seeding core with its own scoreboard
module tb_top;
  import kmpp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS = 64;
  localparam int NCENT = 8;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [2:0]  status;
    logic [2:0]  centroid_number;
    logic [5:0]  chosen_index;
    coord_t      centroid_x;
    coord_t      centroid_y;
    logic [2:0]  group;
    dist_t       min_distance;
  } seed_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_cluster_count = 4'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = FUNC_CLEAR;
  coord_t      in_x_coord = '0;
  coord_t      in_y_coord = '0;
  logic [15:0] in_rand_value = '0;
  logic [5:0]  in_point_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [2:0]  out_centroid_number;
  logic [5:0]  out_chosen_index;
  coord_t      out_centroid_x;
  coord_t      out_centroid_y;
  logic [2:0]  out_group;
  dist_t       out_min_distance;

  kmeans_plus_plus_seeding_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_cluster_count(cfg_cluster_count),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_x_coord(in_x_coord), .in_y_coord(in_y_coord),
    .in_rand_value(in_rand_value), .in_point_index(in_point_index),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_centroid_number(out_centroid_number), .out_chosen_index(out_chosen_index),
    .out_centroid_x(out_centroid_x), .out_centroid_y(out_centroid_y),
    .out_group(out_group), .out_min_distance(out_min_distance)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // scoreboard copy of the block state
  coord_t       pt_x [NPTS];
  coord_t       pt_y [NPTS];
  coord_t       cent_x [NCENT];
  coord_t       cent_y [NCENT];
  int unsigned  pt_count;
  int unsigned  cent_count;
  logic [3:0]   cluster_cnt;

  seed_result_t pending_results[$];
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  int unsigned  n_sent;
  int unsigned  n_checked;
  int unsigned  n_picks;
  int unsigned  n_errors;
  longint unsigned n_cycles;

  function automatic longint unsigned sq_distance(coord_t ax, coord_t ay, coord_t bx,
                                                  coord_t by);
    longint dx;
    longint dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return longint'(dx * dx) + longint'(dy * dy);
  endfunction

  function automatic int unsigned nearest_centroid(int unsigned p,
                                                   output longint unsigned dmin);
    int unsigned best;
    longint unsigned d;
    best = 0;
    dmin = 0;
    for (int unsigned c = 0; c < cent_count; c++) begin
      d = sq_distance(pt_x[p], pt_y[p], cent_x[c], cent_y[c]);
      if (c == 0 || d < dmin) begin
        dmin = d;
        best = c;
      end
    end
    return best;
  endfunction

  function automatic seed_result_t predict_seeding(logic [1:0] func, coord_t x, coord_t y,
                                                   logic [15:0] rnd, logic [5:0] pidx);
    seed_result_t r;
    int unsigned limit;
    int unsigned pick;
    int unsigned g;
    longint unsigned dists [NPTS];
    longint unsigned sum;
    longint unsigned prefix;
    longint unsigned target;
    longint unsigned d;
    r = '{ST_OK, 3'd0, 6'd0, 16'sd0, 16'sd0, 3'd0, '0};
    case (func)
      FUNC_CLEAR: begin
        pt_count = 0;
        cent_count = 0;
      end
      FUNC_LOAD: begin
        if (pt_count >= NPTS) begin
          r.status = ST_FULL;
        end else begin
          pt_x[pt_count] = x;
          pt_y[pt_count] = y;
          pt_count++;
        end
      end
      FUNC_SEED: begin
        limit = cluster_cnt;
        if (limit < 1) limit = 1;
        if (limit > NCENT) limit = NCENT;
        if (pt_count == 0) begin
          r.status = ST_NO_PTS;
        end else if (cent_count >= limit) begin
          r.status = ST_ALL_DONE;
        end else begin
          if (cent_count == 0) begin
            pick = rnd % pt_count;
          end else begin
            sum = 0;
            prefix = 0;
            for (int unsigned j = 0; j < pt_count; j++) begin
              void'(nearest_centroid(j, dists[j]));
              sum += dists[j];
            end
            target = sum * rnd;
            pick = pt_count - 1;
            for (int unsigned j = 0; j < pt_count; j++) begin
              prefix += dists[j];
              if ((prefix << 16) >= target) begin
                pick = j;
                break;
              end
            end
          end
          cent_x[cent_count] = pt_x[pick];
          cent_y[cent_count] = pt_y[pick];
          r.centroid_number = cent_count[2:0];
          r.chosen_index = pick[5:0];
          r.centroid_x = pt_x[pick];
          r.centroid_y = pt_y[pick];
          cent_count++;
          n_picks++;
        end
      end
      default: begin
        if (pidx >= pt_count) begin
          r.status = ST_BAD_IDX;
        end else if (cent_count == 0) begin
          r.status = ST_NO_CENT;
        end else begin
          g = nearest_centroid(pidx, d);
          r.centroid_number = g[2:0];
          r.chosen_index = pidx;
          r.centroid_x = cent_x[g];
          r.centroid_y = cent_y[g];
          r.group = g[2:0];
          r.min_distance = d[32:0];
        end
      end
    endcase
    return r;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_item(logic [1:0] func, coord_t x, coord_t y, logic [15:0] rnd,
                           logic [5:0] pidx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_x_coord <= x;
    in_y_coord <= y;
    in_rand_value <= rnd;
    in_point_index <= pidx;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_seeding(func, x, y, rnd, pidx));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_cluster_count(logic [3:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_cluster_count <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    cluster_cnt = value;
  endtask

  task automatic load(coord_t x, coord_t y);
    send_item(FUNC_LOAD, x, y, 16'($urandom), 6'($urandom));
  endtask

  task automatic seed(logic [15:0] rnd);
    send_item(FUNC_SEED, 16'($urandom), 16'($urandom), rnd, 6'($urandom));
  endtask

  task automatic query(logic [5:0] pidx);
    send_item(FUNC_ASSIGN, 16'($urandom), 16'($urandom), 16'($urandom), pidx);
  endtask

  task automatic clear_store();
    send_item(FUNC_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 6'($urandom));
  endtask

  task automatic test_empty_store();
    seed(16'd0);
    query(6'd0);
    query(6'd63);
    clear_store();
  endtask

  task automatic test_extremes();
    load(16'sh8000, 16'sh8000);
    load(16'sh7fff, 16'sh7fff);
    load(16'sh8000, 16'sh7fff);
    load(16'sd0, 16'sd0);
    query(6'd1);
    seed(16'd1);
    seed(16'd65535);
    seed(16'd0);
    for (int i = 0; i < 5; i++) query(i[5:0]);
    load(16'sh7fff, 16'sh8000);
    query(6'd4);
  endtask

  task automatic test_zero_sum();
    write_cluster_count(4'd3);
    clear_store();
    repeat (3) load(16'sd1234, -16'sd77);
    seed(16'd2);
    seed(16'd65535);
    seed(16'd40000);
    query(6'd2);
  endtask

  task automatic test_full_store();
    write_cluster_count(4'd8);
    clear_store();
    repeat (NPTS) load(16'($urandom), 16'($urandom));
    load(16'sd5, 16'sd5);
    seed(16'd65535);
    repeat (8) seed(16'($urandom));
    query(6'd63);
    query(6'd0);
  endtask

  task automatic test_cluster_limits();
    logic [3:0] settings [3] = '{4'd0, 4'd15, 4'd1};
    foreach (settings[s]) begin
      write_cluster_count(settings[s]);
      clear_store();
      repeat (4) load(16'($urandom), 16'($urandom));
      repeat (9) seed(16'($urandom));
      query(6'd3);
    end
    // lowering the count keeps centroids already chosen
    write_cluster_count(4'd8);
    clear_store();
    repeat (5) load(16'($urandom), 16'($urandom));
    repeat (3) seed(16'($urandom));
    write_cluster_count(4'd2);
    seed(16'($urandom));
    query(6'd4);
  endtask

  task automatic random_sequence();
    int unsigned npts;
    int unsigned nseed;
    if ($urandom_range(3) == 0) write_cluster_count(4'($urandom));
    clear_store();
    npts = ($urandom_range(9) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 12);
    nseed = cluster_cnt + 1;
    for (int unsigned i = 0; i < npts; i++) begin
      if ($urandom_range(15) == 0)
        load($urandom_range(1) ? 16'sh8000 : 16'sh7fff, 16'($urandom));
      else
        load(16'($urandom), 16'($urandom));
    end
    for (int unsigned i = 0; i <= nseed; i++) begin
      seed(16'($urandom));
      if ($urandom_range(2) == 0) query(6'($urandom_range(0, npts + 1)));
      if ($urandom_range(9) == 0) load(16'($urandom), 16'($urandom));
      if ($urandom_range(9) == 0)
        send_item(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  6'($urandom));
    end
    repeat ($urandom_range(1, 4)) query(6'($urandom_range(0, 63)));
  endtask

  task automatic test_random_phase(int unsigned idle_pct, int unsigned stall_pct);
    int unsigned start;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = n_sent;
    while (n_sent - start < 60) random_sequence();
    // hold off until every pending result is back
    drain();
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    seed_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing pending");
        n_errors++;
      end else begin
        e = pending_results.pop_front();
        n_checked++;
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status); n_errors++;
        end
        if (out_centroid_number !== e.centroid_number) begin
          $error("centroid_number: expected %0d, got %0d", e.centroid_number,
                 out_centroid_number); n_errors++;
        end
        if (out_chosen_index !== e.chosen_index) begin
          $error("chosen_index: expected %0d, got %0d", e.chosen_index, out_chosen_index);
          n_errors++;
        end
        if (out_centroid_x !== e.centroid_x) begin
          $error("centroid_x: expected %0d, got %0d", e.centroid_x, out_centroid_x);
          n_errors++;
        end
        if (out_centroid_y !== e.centroid_y) begin
          $error("centroid_y: expected %0d, got %0d", e.centroid_y, out_centroid_y);
          n_errors++;
        end
        if (out_group !== e.group) begin
          $error("group: expected %0d, got %0d", e.group, out_group); n_errors++;
        end
        if (out_min_distance !== e.min_distance) begin
          $error("min_distance: expected %0d, got %0d", e.min_distance, out_min_distance);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    pt_count = 0;
    cent_count = 0;
    cluster_cnt = 4'd2;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    n_sent = 0;
    n_checked = 0;
    n_picks = 0;
    n_errors = 0;
    n_cycles = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_empty_store();
    test_extremes();
    test_zero_sum();
    test_full_store();
    test_cluster_limits();
    test_random_phase(0, 0);
    test_random_phase(81, 0);
    test_random_phase(0, 81);
    test_random_phase(6, 6);
    drain();
    repeat (200) @(negedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      n_errors++;
    end
    $display("covered %0d transactions, %0d results checked, %0d centroids picked",
             n_sent, n_checked, n_picks);
    $display("idle and stall mixes: none, sender 81%%, receiver 81%%, both 6%%");
    if (n_errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule
